// ===== rtl/first_fit_block_allocator_assert.svh =====
// Assertion macros for the first fit block allocator.
// Used by ffba_engine; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FFBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba assertion failed");
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffba assertion failed");
`else
`define FFBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ffba_pkg.sv =====
// Shared types and constants of the first fit block allocator.
// No dependencies.
`default_nettype none
package ffba_pkg;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int HEAP_BLOCKS_DEF = 1024;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 16;
    localparam int CFG_W  = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_HEAP_START = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_END   = 1'b1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_BADPTR  = 2'd3
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// First fit block allocator, top level: configuration registers, stream
// unpacking, sequencer and segment table. Depends on ffba_pkg, ffba_engine,
// ffba_seg_ram.
//
// Takes one request at a time: an allocate of N blocks (tuser 0) or a free of
// a pointer (tuser 1), and returns one result per request with the user
// address in tdata and the status in tuser. The heap is set up on the first
// request that reaches it. The first fit walk and the free walk read one
// segment header at a time through the single read port of the segment
// table, so a request takes longer the more segments it visits. BLOCK_BYTES
// must be a power of two. The segment table needs no clearing after reset.
`default_nettype none
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,  // block_count[15:0], free_address[47:16]
    input  wire logic                 s_axis_tuser,  // req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [31:0]               m_axis_tdata,  // result_address[31:0]
    output logic [1:0]                m_axis_tuser   // status[1:0]
);
    localparam int IW = $clog2(HEAP_BLOCKS);
    localparam int EW = $clog2(HEAP_BLOCKS + 1) + 1;

    logic [ADDR_W-1:0] r_heap_start;
    logic [ADDR_W-1:0] r_heap_end;

    // config writes; bounds are latched into the heap only at setup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= '0;
            r_heap_end   <= ADDR_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAP_START: r_heap_start <= i_cfg_wdata;
                REG_HEAP_END:   r_heap_end   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata;

    ffba_engine #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .HEAP_BLOCKS(HEAP_BLOCKS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_heap_start (r_heap_start),
        .i_heap_end   (r_heap_end),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_count      (s_axis_tdata[15:0]),
        .i_addr       (s_axis_tdata[47:16]),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tuser    (m_axis_tuser),
        .o_mem_we     (w_we),
        .o_mem_waddr  (w_waddr),
        .o_mem_wdata  (w_wdata),
        .o_mem_raddr  (w_raddr),
        .i_mem_rdata  (w_rdata)
    );

    ffba_seg_ram #(
        .DEPTH(HEAP_BLOCKS),
        .WIDTH(EW)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );
endmodule
`default_nettype wire

// ===== rtl/ffba_seg_ram.sv =====
// Segment table memory: one write port, one registered read port.
// No dependencies.
`default_nettype none
module ffba_seg_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ffba_engine.sv =====
// Request sequencer: heap setup, first fit walk, free walk and merge,
// result register. Depends on ffba_pkg and the assertion header.
`default_nettype none
`include "first_fit_block_allocator_assert.svh"
module ffba_engine
    import ffba_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF,
    localparam int IW = $clog2(HEAP_BLOCKS),
    localparam int SW = $clog2(HEAP_BLOCKS + 1),
    localparam int EW = SW + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [ADDR_W-1:0] i_heap_start,
    input  wire logic [ADDR_W-1:0] i_heap_end,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic              i_kind,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [ADDR_W-1:0]      o_m_tdata,
    output logic [1:0]             o_m_tuser,
    output logic                   o_mem_we,
    output logic [IW-1:0]          o_mem_waddr,
    output logic [EW-1:0]          o_mem_wdata,
    output logic [IW-1:0]          o_mem_raddr,
    input  wire logic [EW-1:0]     i_mem_rdata
);
    localparam int CW = SW + 1;
    localparam int BB_SH = $clog2(BLOCK_BYTES);
    localparam int NW = CNT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_ARD, S_ACHK, S_ASPLIT, S_AHEAD, S_FCHK,
        S_FRD, S_FWCHK, S_FNRD, S_FNCHK, S_FWI, S_FWP, S_DONE
    } t_state;

    t_state            r_state;
    logic              r_kind;
    logic [NW-1:0]     r_need;
    logic [ADDR_W-1:0] r_addr;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_h;
    logic [IW-1:0]     r_prev;
    logic              r_prev_free;
    logic              r_has_prev;
    logic [SW-1:0]     r_prev_sz;
    logic [SW-1:0]     r_sz;
    logic              r_ready;
    logic [ADDR_W-1:0] r_base;
    logic [CW-1:0]     r_managed;
    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_res_st;

    // read data fields
    logic          w_fr;
    logic [SW-1:0] w_sz;
    assign w_fr = i_mem_rdata[SW];
    assign w_sz = i_mem_rdata[SW-1:0];

    // setup arithmetic
    logic [ADDR_W:0] w_lo, w_hi, w_span;
    logic [CW-1:0]   w_span_c;
    assign w_lo = ((({1'b0, i_heap_start}) + (ADDR_W+1)'(BLOCK_BYTES - 1)) >> BB_SH) << BB_SH;
    assign w_hi = {1'b0, (i_heap_end >> BB_SH) << BB_SH};
    assign w_span = (w_hi > w_lo) ? ((w_hi - w_lo) >> BB_SH) : '0;
    assign w_span_c = (w_span > (ADDR_W+1)'(HEAP_BLOCKS)) ? CW'(HEAP_BLOCKS)
                                                           : CW'(w_span);

    // free pointer checks
    logic [ADDR_W-1:0] w_hblk, w_h;
    logic              w_fbad;
    assign w_hblk = (r_addr - r_base) >> BB_SH;
    assign w_h    = w_hblk - ADDR_W'(1);
    assign w_fbad = (r_addr < i_heap_start) || (r_addr >= i_heap_end)
                 || (r_addr[BB_SH-1:0] != '0)
                 || ({1'b0, r_addr} < ({1'b0, r_base} + (ADDR_W+1)'(BLOCK_BYTES)))
                 || (w_h >= ADDR_W'(r_managed));

    logic [CW-1:0]     w_i_step, w_nxt, w_split;
    logic [ADDR_W-1:0] w_user;
    assign w_i_step = r_i + CW'(w_sz);
    assign w_nxt    = r_i + CW'(r_sz);
    assign w_split  = r_i + CW'(r_need);
    assign w_user   = r_base + (ADDR_W'(r_i + CW'(1)) << BB_SH);

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_i[IW-1:0];
        o_mem_wdata = '0;
        o_mem_raddr = r_i[IW-1:0];
        unique case (r_state)
            S_SETUP: begin
                o_mem_we    = (w_span_c != '0);
                o_mem_waddr = '0;
                o_mem_wdata = {1'b1, SW'(w_span_c)};
            end
            S_ASPLIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = w_split[IW-1:0];
                o_mem_wdata = {1'b1, r_sz - SW'(r_need)};
            end
            S_AHEAD: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = {1'b0, SW'(r_need)};
            end
            S_FNRD:  o_mem_raddr = w_nxt[IW-1:0];
            S_FWI: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = {1'b1, r_sz};
            end
            S_FWP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_prev;
                o_mem_wdata = {1'b1, r_prev_sz + r_sz};
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ready    <= 1'b0;
            r_base     <= '0;
            r_managed  <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            // S_DONE drives tvalid itself
            if (o_m_tvalid && i_m_tready && r_state != S_DONE) begin
                o_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind     <= i_kind;
                        r_need     <= NW'(i_count) + NW'(1);
                        r_addr     <= i_addr;
                        r_i        <= '0;
                        r_has_prev <= 1'b0;
                        r_res_addr <= '0;
                        if (i_kind == REQ_ALLOC && i_count == '0) begin
                            r_res_st <= ST_ZERO;
                            r_state  <= S_DONE;
                        end else if (i_kind == REQ_FREE && i_addr == '0) begin
                            r_res_st <= ST_BADPTR;
                            r_state  <= S_DONE;
                        end else if (!r_ready) begin
                            r_state <= S_SETUP;
                        end else begin
                            r_state <= (i_kind == REQ_ALLOC) ? S_ARD : S_FCHK;
                        end
                    end
                end
                S_SETUP: begin
                    r_ready   <= 1'b1;
                    r_base    <= w_lo[ADDR_W-1:0];
                    r_managed <= w_span_c;
                    r_state   <= (r_kind == REQ_ALLOC) ? S_ARD : S_FCHK;
                end
                S_ARD: begin
                    if (r_i >= r_managed) begin
                        r_res_st <= ST_NOSPACE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_ACHK;
                    end
                end
                S_ACHK: begin
                    if (w_fr && NW'(w_sz) >= r_need) begin
                        r_sz    <= w_sz;
                        r_state <= (NW'(w_sz) > r_need) ? S_ASPLIT : S_AHEAD;
                    end else if (w_sz == '0) begin
                        r_res_st <= ST_NOSPACE;
                        r_state  <= S_DONE;
                    end else begin
                        r_i     <= w_i_step;
                        r_state <= S_ARD;
                    end
                end
                S_ASPLIT: r_state <= S_AHEAD;
                S_AHEAD: begin
                    r_res_addr <= w_user;
                    r_res_st   <= ST_OK;
                    r_state    <= S_DONE;
                end
                S_FCHK: begin
                    r_h <= CW'(w_h);
                    if (w_fbad) begin
                        r_res_st <= ST_BADPTR;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    if (r_i > r_h) begin
                        r_res_st <= ST_BADPTR;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FWCHK;
                    end
                end
                S_FWCHK: begin
                    if (r_i < r_h) begin
                        if (w_sz == '0) begin
                            r_res_st <= ST_BADPTR;
                            r_state  <= S_DONE;
                        end else begin
                            r_prev      <= r_i[IW-1:0];
                            r_prev_free <= w_fr;
                            r_prev_sz   <= w_sz;
                            r_has_prev  <= 1'b1;
                            r_i         <= w_i_step;
                            r_state     <= S_FRD;
                        end
                    end else if (w_fr) begin
                        // double free
                        r_res_st <= ST_BADPTR;
                        r_state  <= S_DONE;
                    end else begin
                        r_sz    <= w_sz;
                        r_state <= S_FNRD;
                    end
                end
                S_FNRD:  r_state <= (w_nxt < r_managed) ? S_FNCHK : S_FWI;
                S_FNCHK: begin
                    if (w_fr) begin
                        r_sz <= r_sz + w_sz;
                    end
                    r_state <= S_FWI;
                end
                S_FWI: begin
                    r_res_st <= ST_OK;
                    r_state  <= (r_has_prev && r_prev_free) ? S_FWP : S_DONE;
                end
                S_FWP:   r_state <= S_DONE;
                S_DONE: begin
                    if (!o_m_tvalid || i_m_tready) begin
                        o_m_tvalid <= 1'b1;
                        o_m_tdata  <= r_res_addr;
                        o_m_tuser  <= r_res_st;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `FFBA_ASSERT_IMPL(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !o_mem_we)
    `FFBA_ASSERT_IMPL(a_fail_zero_addr, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != ST_OK, o_m_tdata == '0)
    `FFBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state != S_IDLE)
    `FFBA_ASSERT_IMPL(a_walk_ready, i_clk, i_rst_n, r_state == S_ARD || r_state == S_FRD, r_ready)
endmodule
`default_nettype wire

// ===== tb/ffba_checker.sv =====
// Scoreboard for the first fit block allocator: mirrors the heap, predicts each
// result from accepted requests and compares. Depends on ffba_pkg.
module ffba_checker
    import ffba_pkg::*;
#(
    parameter int BLOCK_BYTES = 64,
    parameter int HEAP_BLOCKS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic [47:0]          i_req_data,
    input  logic                 i_req_kind,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  logic [31:0]          i_rsp_addr,
    input  logic [1:0]           i_rsp_status,
    output int                   o_errors,
    output int                   o_pending
);
    typedef struct packed {
        logic [31:0] addr;
        t_status     status;
    } t_result;

    logic [31:0] heap_lo, heap_hi, base;
    logic        ready;
    int unsigned blocks;
    int unsigned seg_len[HEAP_BLOCKS];
    bit          seg_free[HEAP_BLOCKS];
    t_result     expected_q[$];

    assign o_pending = expected_q.size();

    function automatic void setup_heap();
        longint unsigned lo, hi, span;
        lo = heap_lo;
        hi = heap_hi;
        if (lo % BLOCK_BYTES != 0) lo += BLOCK_BYTES - lo % BLOCK_BYTES;
        hi -= hi % BLOCK_BYTES;
        ready = 1;
        base = lo[31:0];
        blocks = 0;
        if (hi <= lo) return;
        span = (hi - lo) / BLOCK_BYTES;
        if (span > HEAP_BLOCKS) span = HEAP_BLOCKS;
        blocks = span;
        seg_len[0] = blocks;
        seg_free[0] = 1;
    endfunction

    function automatic t_result take_blocks(int unsigned n);
        t_result r;
        int unsigned need, i, sz;
        longint unsigned a;
        need = n + 1;
        i = 0;
        r = '{addr: '0, status: ST_NOSPACE};
        while (i < blocks) begin
            sz = seg_len[i];
            if (seg_free[i] && sz >= need) begin
                if (sz > need) begin
                    seg_len[i + need] = sz - need;
                    seg_free[i + need] = 1;
                end
                seg_len[i] = need;
                seg_free[i] = 0;
                a = longint'(base) + longint'(i + 1) * BLOCK_BYTES;
                r.addr = a[31:0];
                r.status = ST_OK;
                return r;
            end
            if (sz == 0) break;
            i += sz;
        end
        return r;
    endfunction

    function automatic t_status release_ptr(logic [31:0] p);
        longint unsigned h;
        int unsigned i, prv, nxt;
        bit has_prv;
        i = 0;
        prv = 0;
        has_prv = 0;
        if (p < heap_lo || p >= heap_hi) return ST_BADPTR;
        if (p % BLOCK_BYTES != 0) return ST_BADPTR;
        if (longint'(p) < longint'(base) + BLOCK_BYTES) return ST_BADPTR;
        h = (longint'(p) - longint'(base)) / BLOCK_BYTES - 1;
        if (h >= blocks) return ST_BADPTR;
        while (i < h) begin
            if (seg_len[i] == 0) return ST_BADPTR;
            prv = i;
            has_prv = 1;
            i += seg_len[i];
        end
        if (i != h || seg_free[i]) return ST_BADPTR;
        seg_free[i] = 1;
        nxt = i + seg_len[i];
        if (nxt < blocks && seg_free[nxt]) seg_len[i] += seg_len[nxt];
        if (has_prv && seg_free[prv]) seg_len[prv] += seg_len[i];
        return ST_OK;
    endfunction

    function automatic t_result predict(logic kind, logic [15:0] n, logic [31:0] p);
        t_result r;
        r = '{addr: '0, status: ST_OK};
        if (kind == REQ_ALLOC) begin
            if (n == 0) r.status = ST_ZERO;
            else begin
                if (!ready) setup_heap();
                r = take_blocks(n);
            end
        end else if (p == 0) r.status = ST_BADPTR;
        else begin
            if (!ready) setup_heap();
            r.status = release_ptr(p);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            heap_lo <= 0;
            heap_hi <= 65536;
            ready = 0;
            base = 0;
            blocks = 0;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                expected_q.push_back(predict(i_req_kind, i_req_data[15:0], i_req_data[47:16]));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h/%0d", i_rsp_addr, i_rsp_status);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.addr !== i_rsp_addr || e.status !== i_rsp_status) begin
                        if (o_errors < 10)
                            $display("mismatch: exp addr %h st %0d, got addr %h st %0d",
                                     e.addr, e.status, i_rsp_addr, i_rsp_status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HEAP_START) heap_lo <= i_cfg_wdata;
                else heap_hi <= i_cfg_wdata;
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// Top of the allocator testbench: drives configuration and requests, random
// output stalls, and gives the verdict. Depends on ffba_pkg, ffba_checker and the RTL.
module tb;
    import ffba_pkg::*;

    localparam int BB = 64;
    localparam int NB = 1024;
    localparam int LIMIT = 40000;  // idle cycles

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_we = 0;
    logic [REG_IDX_W-1:0] i_cfg_idx = REG_HEAP_START;
    logic [CFG_W-1:0]     i_cfg_wdata = 0;
    logic                 s_axis_tvalid = 0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata = 0;   // block_count[15:0], free_address[47:16]
    logic                 s_axis_tuser = 0;   // req_type
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 0;
    logic [31:0]          m_axis_tdata;       // result_address[31:0]
    logic [1:0]           m_axis_tuser;       // status[1:0]
    int errors, pending;
    int idle_cycles = 0;
    bit no_idle = 0;     // last stretch runs without gaps
    bit hold_off = 0;    // long receiver stall, timed in its own process
    logic [31:0] live[$]; // addresses handed out, used for well formed frees

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    first_fit_block_allocator #(.BLOCK_BYTES(BB), .HEAP_BLOCKS(NB)) u_dut (.*);

    ffba_checker #(.BLOCK_BYTES(BB), .HEAP_BLOCKS(NB)) u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_kind(s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_rsp_addr(m_axis_tdata), .i_rsp_status(m_axis_tuser),
        .o_errors(errors), .o_pending(pending));

    // record returned addresses so frees can hit real allocations
    always @(posedge i_clk)
        if (m_axis_tvalid && m_axis_tready && m_axis_tuser == ST_OK && m_axis_tdata != 0)
            live.push_back(m_axis_tdata);

    // receiver: random stall bursts, or a long hold-off when asked
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) m_axis_tready <= 0;
        else if (hold_off) m_axis_tready <= 0;
        else if (no_idle || $urandom_range(0, 2) != 0) m_axis_tready <= 1;
        else begin
            gap = $urandom_range(1, 5);
            m_axis_tready <= 0;
            repeat (gap) @(posedge i_clk);
            m_axis_tready <= 1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // one request, held until accepted; optional random gap first
    task automatic send_request(logic kind, logic [15:0] n, logic [31:0] p);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {p, n};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_free_ptr();
        int k;
        logic [31:0] p;
        if (live.size() == 0 || $urandom_range(0, 9) == 0) return $urandom();
        k = $urandom_range(0, live.size() - 1);
        p = live[k];
        if ($urandom_range(0, 7) != 0) live.delete(k);  // sometimes keep: double free
        return p;
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [15:0] n;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                n = (r < 50) ? 16'($urandom_range(1, 40)) : 16'($urandom());
                send_request(REQ_ALLOC, n, $urandom());
            end else if (r < 95) send_request(REQ_FREE, $urandom(), pick_free_ptr());
            else send_request(r[0], 0, 0);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // setup under configured, unaligned bounds
        cfg_write(REG_HEAP_START, 32'h0000_1010);  // unaligned start
        cfg_write(REG_HEAP_END, 32'h0001_1013);    // unaligned end
        // directed
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_FREE, 16'hffff, 0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_ALLOC, 16'hffff, 32'hffff_ffff);
        send_request(REQ_ALLOC, 1022, 0);
        send_request(REQ_ALLOC, 3, 0);
        send_request(REQ_FREE, 0, 32'h0000_1040 + 32'd64);  // first allocation
        send_request(REQ_FREE, 0, 32'h0000_1080);           // double free
        send_request(REQ_FREE, 0, 32'h0000_1081);           // misaligned
        send_request(REQ_FREE, 0, 32'h0000_0040);           // below start
        send_request(REQ_FREE, 0, 32'hffff_ffc0);           // above end
        send_request(REQ_FREE, 0, 32'h0000_1100);           // second allocation
        send_request(REQ_ALLOC, 2, 0);
        drain();
        live.delete();
        random_phase(120);
        // long receiver stall while requests keep coming
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(30);
        join
        drain();
        // move bounds after setup: range test only changes
        cfg_write(REG_HEAP_START, 32'h0000_4000);
        cfg_write(REG_HEAP_END, 32'hffff_ffff);
        random_phase(150);
        drain();
        cfg_write(REG_HEAP_START, 32'h0000_0000);
        cfg_write(REG_HEAP_END, 32'h0000_0000);
        random_phase(100);
        drain();
        cfg_write(REG_HEAP_START, 32'h0000_1000);
        cfg_write(REG_HEAP_END, 32'h0002_0000);
        no_idle = 1;
        random_phase(160);
        drain();
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
